// File: hdl/mandelbrot_escape_iteration_core_defines.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape iteration core - assertion macros
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_ITERATION_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_ITERATION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define MEI_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);
// Next-cycle implication
`define MEI_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);
`else
`define MEI_ASSERT_IMP(lbl, ant, con, msg)
`define MEI_ASSERT_NXT(lbl, ant, con, msg)
`endif

`endif

// File: hdl/mei_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape iteration package
// Shared types and constants for the controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mei_pkg;

  localparam int POINT_W        = 32;
  localparam int CFG_W          = 16;
  localparam int ITER_OUT_W     = 16;
  localparam int MAX_ITER_RESET = 256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVL,
    ST_ZLIM
  } mei_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic emit;
    logic emit_esc;
  } mei_cmd_t;

  typedef struct packed {
    logic escape;
    logic last;
    logic zero_limit;
    logic out_free;
  } mei_sts_t;

endpackage

// File: hdl/mandelbrot_escape_iteration_core.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape iteration core
// Iterates z = z*z + c from zero for one fixed-point point and reports the
// escape iteration index and an escaped flag.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  point_real, point_imag
//   m_axis    out        m_axis_tvalid/m_axis_tready  iter_count, escaped
//   cfg       in         cfg_valid_i/cfg_ready_o      max_iterations
//
// A point is loaded and then runs n iterations, n the escape index plus one
// or the limit; with a zero limit it is loaded and emitted with no iteration.
// Each iteration is one multiply step and one evaluate step of the z loop.
// Reset sets the limit to 256 and empties the output register.
// A new point is taken while a result waits; the final evaluate step holds
// while the previous result is still untaken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_iteration_core
  import mei_pkg::*;
#(
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*POINT_W-1:0]  s_axis_tdata,  // [31:0] point_real, [63:32] point_imag
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ITER_OUT_W-1:0] m_axis_tdata,  // [15:0] iter_count
  output logic [0:0]            m_axis_tuser   // [0] escaped
);

  mei_cmd_t cmd;
  mei_sts_t sts;
  logic     out_esc;

  assign cfg_ready_o = 1'b1;

  mei_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mei_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_count_o (m_axis_tdata),
    .out_esc_o   (out_esc)
  );

  assign m_axis_tuser[0] = out_esc;

endmodule

// File: hdl/mei_ctrl.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape iteration controller
// Sequences load, multiply and evaluate steps and hands results to the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_iteration_core_defines.svh"

module mei_ctrl
  import mei_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mei_sts_t sts_i,
  output mei_cmd_t cmd_o
);

  mei_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.zero_limit ? ST_ZLIM : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EVL;
      end
      ST_EVL: begin
        if (sts_i.escape || sts_i.last) begin
          // hold until the output register is free
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_esc = sts_i.escape;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_ZLIM: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `MEI_ASSERT_IMP(a_emit_free, cmd_o.emit, sts_i.out_free, "result emitted into a full output")
  `MEI_ASSERT_NXT(a_accept_busy, in_valid_i && in_ready_o,
                  state_q == ST_MUL || state_q == ST_ZLIM, "accepted point not started")
  `MEI_ASSERT_NXT(a_loop_back, state_q == ST_EVL && !sts_i.escape && !sts_i.last,
                  state_q == ST_MUL && !in_ready_o, "iteration did not continue")

endmodule

// File: hdl/mei_datapath.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape iteration datapath
// Holds z, its squares, the cross term, the iteration count, the limit
// register and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mei_datapath
  import mei_pkg::*;
#(
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic [2*POINT_W-1:0]  in_data_i,
  input  mei_cmd_t              cmd_i,
  output mei_sts_t              sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ITER_OUT_W-1:0] out_count_o,
  output logic                  out_esc_o
);

  localparam int MW     = FRAC_BITS + 2;
  localparam int PW     = 2 * MW;
  localparam int ZW     = (FRAC_BITS + 6 > 34) ? FRAC_BITS + 6 : 34;
  localparam int SQ_W   = FRAC_BITS + 3;
  localparam int SUM_W  = SQ_W + 1;
  localparam int TR_W   = PW - FRAC_BITS + 1;

  localparam logic [ZW-1:0]    MAG_LIM  = ZW'(1) << (FRAC_BITS + 1);
  localparam logic [SQ_W-1:0]  SQ_SAT   = (SQ_W'(1) << (FRAC_BITS + 2)) + SQ_W'(1);
  localparam logic [SUM_W-1:0] FOUR_FIX = SUM_W'(1) << (FRAC_BITS + 2);
  localparam logic [TR_W-1:0]  TW_LIM   = (TR_W > 62) ? (TR_W'(1) << 62) : '0;

  logic [COUNT_BITS-1:0]  max_q;
  logic                   out_valid_q;
  logic [ITER_OUT_W-1:0]  out_count_q;
  logic                   out_esc_q;

  logic signed [POINT_W-1:0] c_re_q, c_im_q;
  logic signed [ZW-1:0]      x_q, y_q, tw_q;
  logic [SQ_W-1:0]           xsq_q, ysq_q;
  logic [COUNT_BITS-1:0]     i_q;

  logic [ZW-1:0]        x_mag, y_mag;
  logic                 x_sat, y_sat;
  logic [MW-1:0]        mx, my;
  logic [PW-1:0]        pxx, pyy, pxy;
  logic [SQ_W-1:0]      xsq_d, ysq_d;
  logic [TR_W-1:0]      tr_full, tr_cut, tr_adj;
  logic                 tr_rem, tr_neg;
  logic signed [ZW-1:0] tw_d, x_d, y_d;
  logic [SUM_W-1:0]     sq_sum;

  always_comb begin
    x_mag   = x_q[ZW-1] ? $unsigned(-x_q) : $unsigned(x_q);
    y_mag   = y_q[ZW-1] ? $unsigned(-y_q) : $unsigned(y_q);
    x_sat   = x_mag > MAG_LIM;
    y_sat   = y_mag > MAG_LIM;
    mx      = x_mag[MW-1:0];
    my      = y_mag[MW-1:0];
    pxx     = mx * mx;
    pyy     = my * my;
    pxy     = mx * my;
    xsq_d   = x_sat ? SQ_SAT : pxx[FRAC_BITS+SQ_W-1:FRAC_BITS];
    ysq_d   = y_sat ? SQ_SAT : pyy[FRAC_BITS+SQ_W-1:FRAC_BITS];
    tr_full = pxy[PW-1:FRAC_BITS-1];
    tr_cut  = ((TR_W > 62) && (tr_full > TW_LIM)) ? TW_LIM : tr_full;
    tr_rem  = |pxy[FRAC_BITS-2:0];
    tr_neg  = x_q[ZW-1] ^ y_q[ZW-1];
    // round toward minus infinity on negative products
    tr_adj  = tr_cut + TR_W'(tr_rem);
    tw_d    = tr_neg ? -$signed(ZW'(tr_adj)) : $signed(ZW'(tr_cut));
    x_d     = $signed(ZW'(xsq_q)) - $signed(ZW'(ysq_q)) + ZW'(c_re_q);
    y_d     = tw_q + ZW'(c_im_q);
    sq_sum  = SUM_W'(xsq_q) + SUM_W'(ysq_q);
  end

  assign sts_o.escape     = sq_sum > FOUR_FIX;
  assign sts_o.last       = i_q == (max_q - COUNT_BITS'(1));
  assign sts_o.zero_limit = max_q == '0;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= COUNT_BITS'(MAX_ITER_RESET);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_q <= COUNT_BITS'(cfg_data_i);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_re_q <= $signed(in_data_i[POINT_W-1:0]);
      c_im_q <= $signed(in_data_i[2*POINT_W-1:POINT_W]);
      x_q    <= ZW'($signed(in_data_i[POINT_W-1:0]));
      y_q    <= ZW'($signed(in_data_i[2*POINT_W-1:POINT_W]));
      i_q    <= '0;
    end
    if (cmd_i.mul) begin
      xsq_q <= xsq_d;
      ysq_q <= ysq_d;
      tw_q  <= tw_d;
    end
    if (cmd_i.step) begin
      x_q <= x_d;
      y_q <= y_d;
      i_q <= i_q + COUNT_BITS'(1);
    end
    if (cmd_i.emit) begin
      out_count_q <= cmd_i.emit_esc ? ITER_OUT_W'(i_q) : '0;
      out_esc_q   <= cmd_i.emit_esc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;
  assign out_esc_o   = out_esc_q;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape iteration core - self-checking testbench
// Streams Q4.28 points into the core under several iteration limits and
// checks every escape index and escaped flag against the table or an in-bench
// fixed-point model of the z = z*z + c loop. A short directed table (zero
// point, the field extremes, points that sit exactly on the magnitude bound,
// the zero limit and the full limit) is followed by random points, mostly drawn
// from the region around the set, with random idling on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mei_pkg::*;

  localparam int          FRAC      = 28;
  localparam logic [63:0] FOUR_Q    = 64'd4 << FRAC;
  localparam int          CYC_LIMIT = 4_000_000;
  localparam int          N_ROWS    = 25;
  localparam int          N_PHASES  = 14;

  typedef struct packed {
    logic [ITER_OUT_W-1:0] iter_count;
    logic                  escaped;
  } outcome_t;

  typedef struct packed {
    logic [CFG_W-1:0]      lim;
    logic [POINT_W-1:0]    re;
    logic [POINT_W-1:0]    im;
    logic                  known;
    logic [ITER_OUT_W-1:0] cnt;
    logic                  esc;
  } point_row_t;

  localparam point_row_t POINT_ROWS [N_ROWS] = '{
    '{16'd256,   32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0, 1'b0},
    '{16'd256,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd0, 1'b1},
    '{16'd256,   32'h8000_0000, 32'h8000_0000, 1'b1, 16'd0, 1'b1},
    '{16'd256,   32'h8000_0000, 32'h0000_0000, 1'b1, 16'd0, 1'b1},
    '{16'd256,   32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 16'd0, 1'b1},
    '{16'd256,   32'h0000_0000, 32'h8000_0000, 1'b1, 16'd0, 1'b1},
    '{16'd256,   32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 16'd0, 1'b1},
    '{16'd256,   32'hE000_0000, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{16'd256,   32'h2000_0000, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{16'd256,   32'h0400_0000, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{16'd256,   32'h0428_F5C3, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{16'd256,   32'hF400_0000, 32'h0199_999A, 1'b0, 16'd0, 1'b0},
    '{16'd256,   32'h0000_0000, 32'h1000_0000, 1'b0, 16'd0, 1'b0},
    '{16'd256,   32'hF000_0000, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{16'd256,   32'hEC00_0000, 32'h0333_3333, 1'b0, 16'd0, 1'b0},
    '{16'd256,   32'hFE66_6666, 32'h0A6A_7EFA, 1'b0, 16'd0, 1'b0},
    '{16'd256,   32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 16'd0, 1'b0},
    '{16'd0,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0, 1'b0},
    '{16'd0,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd0, 1'b0},
    '{16'd0,     32'h8000_0000, 32'h8000_0000, 1'b1, 16'd0, 1'b0},
    '{16'd1,     32'h2000_0000, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{16'd1,     32'h2000_0001, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{16'd65535, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 16'd0, 1'b1},
    '{16'd65535, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0, 1'b0},
    '{16'd65535, 32'h0428_F5C3, 32'h0000_0000, 1'b0, 16'd0, 1'b0}
  };

  localparam int PHASE_LIMITS [N_PHASES] = '{1, 2, 3, 5, 8, 16, 33, 64, 100, 255, 1023, 0, 7, 40};
  localparam int PHASE_POINTS [N_PHASES] = '{90, 90, 90, 90, 90, 90, 90, 90, 90, 90, 40, 30, 90, 90};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*POINT_W-1:0]  s_axis_tdata  = '0;  // [31:0] point_real, [63:32] point_imag
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [ITER_OUT_W-1:0] m_axis_tdata;        // [15:0] iter_count
  logic [0:0]            m_axis_tuser;        // [0] escaped

  outcome_t         escape_q [$];
  outcome_t         head_r;
  logic [CFG_W-1:0] iter_limit = CFG_W'(MAX_ITER_RESET);
  bit               steady     = 1'b0;
  int               errors     = 0;
  int               points_in  = 0;
  int               checked    = 0;
  int               escapes    = 0;
  int               limit_writes = 0;
  int               cycle_cnt  = 0;

  mandelbrot_escape_iteration_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // square scaled back to Q.28, held just above 4
  function automatic logic [63:0] fx_square(input logic signed [63:0] v);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [127:0] scaled;
    mag    = v[63] ? -v : v;
    prod   = {64'd0, mag} * {64'd0, mag};
    scaled = prod >> FRAC;
    if (scaled > {64'd0, FOUR_Q}) return FOUR_Q + 64'd1;
    return scaled[63:0];
  endfunction

  // 2*a*b in Q.28, rounded toward minus infinity
  function automatic logic signed [63:0] fx_twice_product(input logic signed [63:0] a,
                                                          input logic signed [63:0] b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] prod;
    logic [127:0] scaled;
    logic [63:0]  r;
    logic         neg;
    logic         rem;
    neg    = a[63] ^ b[63];
    ma     = a[63] ? -a : a;
    mb     = b[63] ? -b : b;
    prod   = {64'd0, ma} * {64'd0, mb};
    rem    = |prod[FRAC-2:0];
    scaled = prod >> (FRAC - 1);
    r      = (scaled > (128'd1 << 62)) ? (64'd1 << 62) : scaled[63:0];
    if (neg) return -$signed(r + {63'd0, rem});
    return $signed(r);
  endfunction

  function automatic outcome_t escape_outcome(input logic signed [POINT_W-1:0] re,
                                              input logic signed [POINT_W-1:0] im,
                                              input logic [CFG_W-1:0] lim);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] cr;
    logic signed [63:0] ci;
    logic [63:0]        xs;
    logic [63:0]        ys;
    outcome_t           res;
    x   = '0;
    y   = '0;
    xs  = '0;
    ys  = '0;
    cr  = re;
    ci  = im;
    res = '0;
    for (int unsigned i = 0; i < lim; i++) begin
      y  = fx_twice_product(x, y) + ci;
      x  = $signed(xs) - $signed(ys) + cr;
      xs = fx_square(x);
      ys = fx_square(y);
      if (xs + ys > FOUR_Q) begin
        res.iter_count = i[ITER_OUT_W-1:0];
        res.escaped    = 1'b1;
        return res;
      end
    end
    return res;
  endfunction

  task automatic send_point(input logic [POINT_W-1:0] re, input logic [POINT_W-1:0] im,
                            input bit known, input outcome_t typed);
    if (!steady && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im, re};
    do @(posedge clk_i); while (!s_axis_tready);
    escape_q.push_back(known ? typed : escape_outcome(re, im, iter_limit));
    points_in++;
  endtask

  // drain the core, then transfer a new limit
  task automatic write_limit(input logic [CFG_W-1:0] lim);
    s_axis_tvalid <= 1'b0;
    while (escape_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    iter_limit  = lim;
    limit_writes++;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (escape_q.size() == 0) begin
        $error("result transfer with no point outstanding");
        errors++;
      end else begin
        head_r = escape_q.pop_front();
        checked++;
        if (m_axis_tuser[0]) escapes++;
        if (m_axis_tdata !== head_r.iter_count) begin
          $error("iter_count: expected %0d, actual %0d", head_r.iter_count, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== head_r.escaped) begin
          $error("escaped: expected %0d, actual %0d", head_r.escaped, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYC_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    point_row_t         row;
    outcome_t           typed;
    logic [POINT_W-1:0] re;
    logic [POINT_W-1:0] im;
    int                 pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_ROWS; r++) begin
      row = POINT_ROWS[r];
      if (row.lim != iter_limit) write_limit(row.lim);
      typed.iter_count = row.cnt;
      typed.escaped    = row.esc;
      send_point(row.re, row.im, row.known, typed);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_limit(CFG_W'(PHASE_LIMITS[p]));
      steady = (p == 4);
      for (int n = 0; n < PHASE_POINTS[p]; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          re = $urandom;
          im = $urandom;
        end else if (pick < 25) begin
          // near the origin and the main cardioid
          re = POINT_W'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
          im = POINT_W'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
        end else begin
          // real in [-2.5, 1.0], imaginary in [-1.5, 1.5]
          re = POINT_W'($urandom_range(0, 32'h3800_0000)) - 32'h2800_0000;
          im = POINT_W'($urandom_range(0, 32'h3000_0000)) - 32'h1800_0000;
        end
        send_point(re, im, 1'b0, '0);
      end
      steady = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    while (escape_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d points, checked %0d results (%0d escaped, %0d held to the limit)",
             points_in, checked, escapes, checked - escapes);
    $display("Limit register written %0d times, from the zero limit up to 65535",
             limit_writes);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
